FILE: rtl/kvb_pkg.sv
// Shared types and constants for the keyframe vertex blender.
package kvb_pkg;

	localparam int FRAME_W   = 6;
	localparam int NXT_W     = 7;
	localparam int VSEL_W    = 9;
	localparam int STEP_W    = 16;
	localparam int FRACOUT_W = 16;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SEQ_FIRST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LAST  = 2'd1;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_TICK = 2'd1,
		OP_READ = 2'd2
	} kvb_op_t;

	// state reported with every result
	typedef struct packed {
		logic [FRAME_W-1:0]   frame_now;
		logic [NXT_W-1:0]     frame_after;
		logic [FRACOUT_W-1:0] blend_frac;
	} kvb_status_t;

	// per-lane pipeline control from the top level
	typedef struct packed {
		logic en_s1;    // RAM read register advances
		logic en_s2;
		logic en_s3;
		logic a_ok_s1;  // current frame lies in the store
		logic b_ok_s1;  // next frame lies in the store
	} kvb_lane_ctl_t;

endpackage

FILE: rtl/kvb_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module kvb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: rtl/kvb_lane.sv
// One coordinate lane: frame store plus difference, multiply and add stages.
module kvb_lane #(
	parameter int COORD_BITS = 24,
	parameter int FRAC_BITS  = 16,
	parameter int DEPTH      = 32768
) (
	input  logic                     clk,
	input  kvb_pkg::kvb_lane_ctl_t   ctl,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [COORD_BITS-1:0]    wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	input  logic [FRAC_BITS-1:0]     acc_s2,
	output logic [COORD_BITS-1:0]    sum
);

	import kvb_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int PW = DW + FRAC_BITS + 1;

	logic [COORD_BITS-1:0] rdata_a;
	logic [COORD_BITS-1:0] rdata_b;
	logic [COORD_BITS-1:0] a_s1;
	logic [COORD_BITS-1:0] b_s1;
	logic [COORD_BITS-1:0] a_s2;
	logic signed [DW-1:0]  diff_s2;
	logic [COORD_BITS-1:0] a_s3;
	logic signed [PW-1:0]  prod_s3;
	logic signed [PW-1:0]  prod_sh;

	kvb_ram #(
		.WIDTH(COORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.re      (ctl.en_s1),
		.raddr_a (rd_addr_a),
		.raddr_b (rd_addr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// frames outside the store read as zero
	assign a_s1 = ctl.a_ok_s1 ? rdata_a : '0;
	assign b_s1 = ctl.b_ok_s1 ? rdata_b : '0;

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			a_s2    <= a_s1;
			diff_s2 <= $signed({b_s1[COORD_BITS-1], b_s1}) - $signed({a_s1[COORD_BITS-1], a_s1});
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			a_s3    <= a_s2;
			prod_s3 <= PW'(diff_s2) * PW'($signed({1'b0, acc_s2}));
		end
	end

	// floor shift; result lies between the two frames
	assign prod_sh = prod_s3 >>> FRAC_BITS;
	assign sum     = a_s3 + prod_sh[COORD_BITS-1:0];

endmodule

FILE: rtl/keyframe_vertex_blender.sv
// Keyframe vertex blender: frame stores, sequence control and result merge.
// Throughput: one beat per cycle, every opcode, while out_stall does not hold the pipe;
// each coordinate lane has a store with two read ports (current and next frame) and a
// three-stage blend pipe. Reset clears the frame state, the sequence registers and all
// valid bits; the vertex stores are not cleared and hold nothing defined until loaded.
module keyframe_vertex_blender #(
	parameter int MAX_FRAMES   = 64,
	parameter int MAX_VERTICES = 512,
	parameter int FRAC_BITS    = 16,
	parameter int COORD_BITS   = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input beats
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      opcode,
	input  logic [kvb_pkg::FRAME_W-1:0]     frame_sel,
	input  logic [kvb_pkg::VSEL_W-1:0]      vertex_sel,
	input  logic signed [COORD_BITS-1:0]    pos_x_in,
	input  logic signed [COORD_BITS-1:0]    pos_y_in,
	input  logic signed [COORD_BITS-1:0]    pos_z_in,
	input  logic [kvb_pkg::STEP_W-1:0]      time_step,
	// result beats
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [COORD_BITS-1:0]    blend_x,
	output logic signed [COORD_BITS-1:0]    blend_y,
	output logic signed [COORD_BITS-1:0]    blend_z,
	output logic [kvb_pkg::FRAME_W-1:0]     frame_now,
	output logic [kvb_pkg::NXT_W-1:0]       frame_after,
	output logic [kvb_pkg::FRACOUT_W-1:0]   blend_frac,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [kvb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kvb_pkg::FRAME_W-1:0]     cfg_data
);

	import kvb_pkg::*;

	localparam int DEPTH = MAX_FRAMES * MAX_VERTICES;
	localparam int AW    = $clog2(DEPTH);
	localparam int SUM_W = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;

	// sequence registers
	logic [FRAME_W-1:0] seq_first_q;
	logic [FRAME_W-1:0] seq_last_q;

	// animation state
	logic [FRAME_W-1:0]   cur_q;
	logic [NXT_W-1:0]     nxt_q;
	logic [FRAC_BITS-1:0] acc_q;

	// pipeline enables: a stage moves when it is empty or the next one moves
	logic en_s1, en_s2, en_s3, en_out;
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic accept;

	// tick arithmetic
	logic [SUM_W-1:0]     acc_sum;
	logic                 wrap;
	logic [FRAME_W-1:0]   cur_r;
	logic [NXT_W-1:0]     nxt_r;
	logic [FRAME_W-1:0]   tick_cur;
	logic [NXT_W-1:0]     tick_nxt;
	logic [FRAC_BITS-1:0] tick_acc;

	logic        is_load, is_tick, is_read;
	logic        vtx_ok, load_ok;
	kvb_status_t status_in;

	logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

	// pipeline payload
	logic                 a_ok_s1, b_ok_s1, rd_ok_s1, rd_ok_s2, rd_ok_s3;
	logic [FRAC_BITS-1:0] acc_s1, acc_s2;
	kvb_status_t          status_s1, status_s2, status_s3, status_q;

	kvb_lane_ctl_t lane_ctl;
	logic [COORD_BITS-1:0] sum_x, sum_y, sum_z;
	logic [COORD_BITS-1:0] blend_x_q, blend_y_q, blend_z_q;

	// ---------------------------------------------------------------
	// Configuration: always ready; user, not block, sees it written only while idle
	// ---------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_first_q <= '0;
			seq_last_q  <= FRAME_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SEQ_FIRST: seq_first_q <= cfg_data;
				CFG_SEQ_LAST:  seq_last_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Handshake and stage enables
	// ---------------------------------------------------------------
	assign en_out   = !out_valid_q || !out_stall;
	assign en_s3    = !v_s3 || en_out;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign accept   = in_valid && en_s1;

	assign is_load = (opcode == OP_LOAD);
	assign is_tick = (opcode == OP_TICK);
	assign is_read = (opcode == OP_READ);

	assign vtx_ok  = int'(vertex_sel) < MAX_VERTICES;
	assign load_ok = is_load && vtx_ok && (int'(frame_sel) < MAX_FRAMES);

	// ---------------------------------------------------------------
	// Tick: blend accumulate and frame advance
	// ---------------------------------------------------------------
	always_comb begin
		acc_sum = SUM_W'(acc_q) + SUM_W'(time_step);
		wrap    = acc_sum >= (SUM_W'(1) << FRAC_BITS);

		// a current frame outside the sequence restarts it first
		if (cur_q < seq_first_q || cur_q > seq_last_q) begin
			cur_r = seq_first_q;
			nxt_r = NXT_W'(seq_first_q) + NXT_W'(1);
		end else begin
			cur_r = cur_q;
			nxt_r = nxt_q;
		end

		tick_cur = cur_r;
		tick_nxt = nxt_r;
		tick_acc = acc_sum[FRAC_BITS-1:0];
		if (wrap) begin
			tick_acc = '0;
			if (cur_r == seq_last_q) begin
				tick_cur = seq_first_q;
				tick_nxt = NXT_W'(seq_first_q) + NXT_W'(1);
			end else if (nxt_r == NXT_W'(seq_last_q)) begin
				tick_cur = nxt_r[FRAME_W-1:0];
				tick_nxt = NXT_W'(seq_first_q);
			end else begin
				tick_cur = nxt_r[FRAME_W-1:0];
				tick_nxt = NXT_W'(nxt_r[FRAME_W-1:0]) + NXT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			nxt_q <= NXT_W'(1);
			acc_q <= '0;
		end else if (accept && is_tick) begin
			cur_q <= tick_cur;
			nxt_q <= tick_nxt;
			acc_q <= tick_acc;
		end
	end

	// state after this beat
	always_comb begin
		if (is_tick) begin
			status_in.frame_now   = tick_cur;
			status_in.frame_after = tick_nxt;
			status_in.blend_frac  = FRACOUT_W'(tick_acc);
		end else begin
			status_in.frame_now   = cur_q;
			status_in.frame_after = nxt_q;
			status_in.blend_frac  = FRACOUT_W'(acc_q);
		end
	end

	// ---------------------------------------------------------------
	// Store addressing: frame * MAX_VERTICES + vertex
	// ---------------------------------------------------------------
	assign wr_addr   = AW'(int'(frame_sel) * MAX_VERTICES + int'(vertex_sel));
	assign rd_addr_a = AW'(int'(cur_q) * MAX_VERTICES + int'(vertex_sel));
	assign rd_addr_b = AW'(int'(nxt_q) * MAX_VERTICES + int'(vertex_sel));

	// ---------------------------------------------------------------
	// Pipeline control and side payload
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1        <= accept;
			if (en_s2)  v_s2        <= v_s1;
			if (en_s3)  v_s3        <= v_s2;
			if (en_out) out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			a_ok_s1   <= int'(cur_q) < MAX_FRAMES;
			b_ok_s1   <= int'(nxt_q) < MAX_FRAMES;
			rd_ok_s1  <= is_read && vtx_ok;
			acc_s1    <= acc_q;
			status_s1 <= status_in;
		end
		if (en_s2) begin
			rd_ok_s2  <= rd_ok_s1;
			acc_s2    <= acc_s1;
			status_s2 <= status_s1;
		end
		if (en_s3) begin
			rd_ok_s3  <= rd_ok_s2;
			status_s3 <= status_s2;
		end
	end

	assign lane_ctl.en_s1   = en_s1;
	assign lane_ctl.en_s2   = en_s2;
	assign lane_ctl.en_s3   = en_s3;
	assign lane_ctl.a_ok_s1 = a_ok_s1;
	assign lane_ctl.b_ok_s1 = b_ok_s1;

	// ---------------------------------------------------------------
	// Coordinate lanes
	// ---------------------------------------------------------------
	kvb_lane #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.DEPTH     (DEPTH)
	) u_lane_x (
		.clk       (clk),
		.ctl       (lane_ctl),
		.wr_en     (accept && load_ok),
		.wr_addr   (wr_addr),
		.wr_data   (pos_x_in),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.acc_s2    (acc_s2),
		.sum       (sum_x)
	);

	kvb_lane #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.DEPTH     (DEPTH)
	) u_lane_y (
		.clk       (clk),
		.ctl       (lane_ctl),
		.wr_en     (accept && load_ok),
		.wr_addr   (wr_addr),
		.wr_data   (pos_y_in),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.acc_s2    (acc_s2),
		.sum       (sum_y)
	);

	kvb_lane #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.DEPTH     (DEPTH)
	) u_lane_z (
		.clk       (clk),
		.ctl       (lane_ctl),
		.wr_en     (accept && load_ok),
		.wr_addr   (wr_addr),
		.wr_data   (pos_z_in),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.acc_s2    (acc_s2),
		.sum       (sum_z)
	);

	// ---------------------------------------------------------------
	// Merge: coordinates only for in-range reads, zero otherwise
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en_out) begin
			blend_x_q <= rd_ok_s3 ? sum_x : '0;
			blend_y_q <= rd_ok_s3 ? sum_y : '0;
			blend_z_q <= rd_ok_s3 ? sum_z : '0;
			status_q  <= status_s3;
		end
	end

	assign out_valid   = out_valid_q;
	assign blend_x     = blend_x_q;
	assign blend_y     = blend_y_q;
	assign blend_z     = blend_z_q;
	assign frame_now   = status_q.frame_now;
	assign frame_after = status_q.frame_after;
	assign blend_frac  = status_q.blend_frac;

endmodule

FILE: rtl/kvb_checker.sv
// Port-level assertions for the keyframe vertex blender, with its bind.
module kvb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [kvb_pkg::FRAME_W-1:0]   frame_now,
	input logic [kvb_pkg::NXT_W-1:0]     frame_after,
	input logic [kvb_pkg::FRACOUT_W-1:0] blend_frac
);

	import kvb_pkg::*;

	// a stalled result beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its state fields
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(frame_now) && $stable(frame_after)
			&& $stable(blend_frac))
		else $error("result beat changed while stalled");

	// with the output register empty the whole pipe can move
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with output register empty");

	// next frame never goes past one above the largest frame index
	a_after_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_after <= NXT_W'(64))
		else $error("next frame out of range");

endmodule

bind keyframe_vertex_blender kvb_checker u_kvb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.frame_now   (frame_now),
	.frame_after (frame_after),
	.blend_frac  (blend_frac)
);

FILE: sim/kvb_tb_pkg.sv
`timescale 1ns / 1ps
// Beat types and the scoreboard that predicts and checks blended vertex results.
package kvb_tb_pkg;
	import kvb_pkg::*;

	localparam int N_FRAMES = 64;
	localparam int N_VERTS  = 512;
	localparam int FRAC     = 16;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

	localparam logic [23:0] COORD_MAX = 24'h7FFFFF;
	localparam logic [23:0] COORD_MIN = 24'h800000;

	typedef struct packed {
		logic [1:0]         op;
		logic [FRAME_W-1:0] fsel;
		logic [VSEL_W-1:0]  vsel;
		logic [23:0]        px;
		logic [23:0]        py;
		logic [23:0]        pz;
		logic [STEP_W-1:0]  step;
	} in_beat_t;

	typedef struct packed {
		logic [23:0] bx;
		logic [23:0] by;
		logic [23:0] bz;
		kvb_status_t st;
	} out_beat_t;

	class vertex_blend_tracker;
		logic [71:0]        vtx_mem [int];   // {x, y, z} per frame/vertex slot
		logic [FRAME_W-1:0] seq_first;
		logic [FRAME_W-1:0] seq_last;
		logic [FRAME_W-1:0] cur;
		logic [NXT_W-1:0]   nxt;
		logic [16:0]        acc;
		out_beat_t          pending_blends [$];
		int errors;
		int noted;
		int checked;
		int reads;
		int advances;

		function new();
			seq_first = '0;
			seq_last  = 6'd1;
			cur       = '0;
			nxt       = 7'd1;
			acc       = '0;
			errors    = 0;
			noted     = 0;
			checked   = 0;
			reads     = 0;
			advances  = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAME_W-1:0] val);
			if (idx == CFG_SEQ_FIRST)
				seq_first = val;
			else if (idx == CFG_SEQ_LAST)
				seq_last = val;
		endfunction

		function int slot(logic [NXT_W-1:0] f, logic [VSEL_W-1:0] v);
			return int'(f) * N_VERTS + int'(v);
		endfunction

		// frames past the store read as zero, so they never block a read
		function bit loaded(logic [NXT_W-1:0] f, logic [VSEL_W-1:0] v);
			if (f >= N_FRAMES)
				return 1'b1;
			return vtx_mem.exists(slot(f, v));
		endfunction

		function bit can_read(logic [VSEL_W-1:0] v);
			return loaded({1'b0, cur}, v) && loaded(nxt, v);
		endfunction

		function logic [71:0] fetch(logic [NXT_W-1:0] f, logic [VSEL_W-1:0] v);
			if (f >= N_FRAMES || !vtx_mem.exists(slot(f, v)))
				return '0;
			return vtx_mem[slot(f, v)];
		endfunction

		// a + floor((b - a) * blend / one), full-width product
		function logic [23:0] lerp(logic [23:0] a, logic [23:0] b);
			longint d;
			longint p;
			d = longint'($signed(b)) - longint'($signed(a));
			p = d * longint'(acc);
			return 24'(longint'($signed(a)) + (p >>> FRAC));
		endfunction

		function void restart();
			cur = seq_first;
			nxt = {1'b0, seq_first} + 7'd1;
		endfunction

		function void note_beat(in_beat_t b);
			out_beat_t   r;
			logic [71:0] va;
			logic [71:0] vb;
			r = '0;
			noted++;
			case (b.op)
				OP_LOAD: begin
					vtx_mem[slot({1'b0, b.fsel}, b.vsel)] = {b.px, b.py, b.pz};
				end
				OP_TICK: begin
					acc = acc + 17'(b.step);
					if (cur < seq_first || cur > seq_last)
						restart();
					if (acc >= 17'h10000) begin
						acc = '0;
						advances++;
						if (cur == seq_last) begin
							restart();
						end else if (nxt == {1'b0, seq_last}) begin
							cur = nxt[FRAME_W-1:0];
							nxt = {1'b0, seq_first};
						end else begin
							cur = nxt[FRAME_W-1:0];
							nxt = {1'b0, cur} + 7'd1;
						end
					end
				end
				OP_READ: begin
					va = fetch({1'b0, cur}, b.vsel);
					vb = fetch(nxt, b.vsel);
					r.bx = lerp(va[71:48], vb[71:48]);
					r.by = lerp(va[47:24], vb[47:24]);
					r.bz = lerp(va[23:0], vb[23:0]);
					reads++;
				end
				default: ;
			endcase
			r.st.frame_now   = cur;
			r.st.frame_after = nxt;
			r.st.blend_frac  = acc[FRACOUT_W-1:0];
			pending_blends.push_back(r);
		endfunction

		function void compare_field(string name, logic signed [31:0] want,
				logic signed [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_beat(out_beat_t got);
			out_beat_t want;
			checked++;
			if (pending_blends.size() == 0) begin
				$error("result beat arrived with nothing outstanding");
				errors++;
				return;
			end
			want = pending_blends.pop_front();
			compare_field("blend_x", $signed(want.bx), $signed(got.bx));
			compare_field("blend_y", $signed(want.by), $signed(got.by));
			compare_field("blend_z", $signed(want.bz), $signed(got.bz));
			compare_field("frame_now", want.st.frame_now, got.st.frame_now);
			compare_field("frame_after", want.st.frame_after, got.st.frame_after);
			compare_field("blend_frac", want.st.blend_frac, got.st.blend_frac);
		endfunction
	endclass

endpackage

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench: drives load/tick/read beats and sequence settings, checks results.
module tb_top;
	import kvb_pkg::*;
	import kvb_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on any channel
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_BEATS    = 88;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// input channel
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            opcode = '0;
	logic [FRAME_W-1:0]    frame_sel = '0;
	logic [VSEL_W-1:0]     vertex_sel = '0;
	logic signed [23:0]    pos_x_in = '0;
	logic signed [23:0]    pos_y_in = '0;
	logic signed [23:0]    pos_z_in = '0;
	logic [STEP_W-1:0]     time_step = '0;

	// result channel
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [23:0]    blend_x;
	logic signed [23:0]    blend_y;
	logic signed [23:0]    blend_z;
	logic [FRAME_W-1:0]    frame_now;
	logic [NXT_W-1:0]      frame_after;
	logic [FRACOUT_W-1:0]  blend_frac;

	// register writes
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [FRAME_W-1:0]    cfg_data = '0;

	vertex_blend_tracker tracker;
	bit          send_calm = 1'b0;
	bit          take_calm = 1'b0;
	int          idle_cycles = 0;
	int          settings = 0;
	logic [8:0]  hot_verts [8];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	keyframe_vertex_blender u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.frame_sel   (frame_sel),
		.vertex_sel  (vertex_sel),
		.pos_x_in    (pos_x_in),
		.pos_y_in    (pos_y_in),
		.pos_z_in    (pos_z_in),
		.time_step   (time_step),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.blend_x     (blend_x),
		.blend_y     (blend_y),
		.blend_z     (blend_z),
		.frame_now   (frame_now),
		.frame_after (frame_after),
		.blend_frac  (blend_frac),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Per-beat wait, drawn at random. Now and then a side flips into a calm
	// stretch where it never idles, so back-to-back traffic gets exercised too.
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 29) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	// extremes show up often, the rest is full-range noise
	function automatic logic [23:0] draw_coord();
		case ($urandom_range(0, 7))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3: return '1;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic in_beat_t make_beat(logic [1:0] op, logic [FRAME_W-1:0] f,
			logic [VSEL_W-1:0] v, logic [23:0] x, logic [23:0] y, logic [23:0] z,
			logic [STEP_W-1:0] step);
		in_beat_t b;
		b.op   = op;
		b.fsel = f;
		b.vsel = v;
		b.px   = x;
		b.py   = y;
		b.pz   = z;
		b.step = step;
		return b;
	endfunction

	// One input beat. Valid stays high across back-to-back beats; it only
	// drops when a gap is drawn. The tracker sees the beat at its accept edge.
	task automatic send_beat(input in_beat_t b);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= b.op;
		frame_sel  <= b.fsel;
		vertex_sel <= b.vsel;
		pos_x_in   <= b.px;
		pos_y_in   <= b.py;
		pos_z_in   <= b.pz;
		time_step  <= b.step;
		do @(posedge clk); while (in_stall);
		tracker.note_beat(b);
	endtask

	// Leaves cfg_valid high so back-to-back writes never lower and raise it
	// in one step; the caller drops it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAME_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, val);
	endtask

	// Stop sending, let every outstanding result come back, then give the
	// pipe a few extra cycles before touching the registers.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending_blends.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_seq(input logic [FRAME_W-1:0] first, input logic [FRAME_W-1:0] last);
		drain();
		// writes to the unused indexes must leave the sequence alone
		if ($urandom_range(0, 2) == 0)
			write_reg($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI, 6'($urandom));
		if ($urandom_range(0, 1)) begin
			write_reg(CFG_SEQ_FIRST, first);
			write_reg(CFG_SEQ_LAST, last);
		end else begin
			write_reg(CFG_SEQ_LAST, last);
			write_reg(CFG_SEQ_FIRST, first);
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Random traffic. Reads only go out when both frames of the blend hold
	// the vertex; otherwise the missing one is loaded first, so most reads
	// land on real data while frames keep advancing under random ticks.
	task automatic run_phase(input int n);
		in_beat_t    b;
		logic [8:0]  v;
		int          pick;
		repeat (n) begin
			b.op   = OP_SPARE;
			b.fsel = 6'($urandom);
			b.vsel = 9'($urandom);
			b.px   = draw_coord();
			b.py   = draw_coord();
			b.pz   = draw_coord();
			b.step = 16'($urandom);
			pick   = $urandom_range(0, 99);
			v      = ($urandom_range(0, 3) == 0) ? 9'($urandom) : hot_verts[$urandom_range(0, 7)];
			if (pick < 45) begin
				b.vsel = v;
				if (tracker.can_read(v)) begin
					b.op = OP_READ;
				end else begin
					b.op   = OP_LOAD;
					b.fsel = tracker.loaded({1'b0, tracker.cur}, v) ?
						tracker.nxt[FRAME_W-1:0] : tracker.cur;
				end
			end else if (pick < 70) begin
				b.op = OP_TICK;
				case ($urandom_range(0, 5))
					0: b.step = '1;
					1: b.step = '0;
					2: b.step = 16'($urandom_range(1, 255));
					default: ;
				endcase
			end else if (pick < 95) begin
				b.op = OP_LOAD;
				if ($urandom_range(0, 2) != 0) begin
					b.vsel = v;
					case ($urandom_range(0, 2))
						0: b.fsel = tracker.cur;
						1: b.fsel = tracker.nxt[FRAME_W-1:0];
						default: b.fsel = 6'($urandom_range(tracker.seq_first, tracker.seq_last));
					endcase
				end
			end
			send_beat(b);
		end
	endtask

	// Result side: hold stall for a drawn number of cycles, then take the
	// next beat and check it against the oldest prediction.
	initial begin : take_results
		out_beat_t got;
		int        hold;
		@(posedge arst_n);
		forever begin
			hold = draw_wait(take_calm);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got.bx             = blend_x;
			got.by             = blend_y;
			got.bz             = blend_z;
			got.st.frame_now   = frame_now;
			got.st.frame_after = frame_after;
			got.st.blend_frac  = blend_frac;
			tracker.check_beat(got);
		end
	end

	// hang detector: any beat on any channel resets the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: no progress for %0d cycles", idle_cycles);
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [11:0] seq_plan [10];
		tracker = new();
		hot_verts = '{9'd0, 9'd511, 9'd1, 9'd256, 9'd170, 9'd341, 9'($urandom), 9'($urandom)};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sequence is frames 0..1. Opposite extremes in the two frames
		// give the widest possible difference through the blend.
		send_beat(make_beat(OP_LOAD, 6'd0, 9'd0, COORD_MAX, COORD_MIN, '0, '0));
		send_beat(make_beat(OP_LOAD, 6'd1, 9'd0, COORD_MIN, COORD_MAX, '1, '0));
		send_beat(make_beat(OP_READ, '0, 9'd0, '0, '0, '0, '0));
		send_beat(make_beat(OP_TICK, '0, '0, '0, '0, '0, 16'h8000));
		send_beat(make_beat(OP_READ, '0, 9'd0, '0, '0, '0, '0));
		send_beat(make_beat(OP_LOAD, 6'd0, 9'd511, draw_coord(), draw_coord(), draw_coord(), '0));
		send_beat(make_beat(OP_LOAD, 6'd1, 9'd511, draw_coord(), draw_coord(), draw_coord(), '0));
		// blend wraps; next frame is the last one, so next goes back to first
		send_beat(make_beat(OP_TICK, '0, '0, '0, '0, '0, 16'hFFFF));
		send_beat(make_beat(OP_READ, '0, 9'd511, '0, '0, '0, '0));
		// largest fraction just below one
		send_beat(make_beat(OP_TICK, '0, '0, '0, '0, '0, 16'hFFFF));
		send_beat(make_beat(OP_READ, '0, 9'd0, '0, '0, '0, '0));
		// current frame is the last one: sequence restarts
		send_beat(make_beat(OP_TICK, '0, '0, '0, '0, '0, 16'd1));
		send_beat(make_beat(OP_TICK, '0, '0, '0, '0, '0, '0));
		send_beat(make_beat(OP_LOAD, 6'd63, 9'd511, '1, '1, '1, '0));
		// unused opcode with every field bit set: nothing moves
		send_beat(make_beat(OP_SPARE, '1, '1, '1, '1, '1, '1));
		send_beat(make_beat(OP_READ, '0, 9'd511, '0, '0, '0, '0));

		// One-frame sequence at the top of the store: current is out of
		// sequence and restarts at 63, so the next frame lies past the store.
		set_seq(6'd63, 6'd63);
		send_beat(make_beat(OP_LOAD, 6'd63, 9'd5, draw_coord(), draw_coord(), draw_coord(), '0));
		send_beat(make_beat(OP_TICK, '0, '0, '0, '0, '0, 16'h4000));
		send_beat(make_beat(OP_READ, '0, 9'd5, '0, '0, '0, '0));
		// last below first: restart at 63, then advancing past 63 wraps to 0
		set_seq(6'd63, 6'd0);
		send_beat(make_beat(OP_TICK, '0, '0, '0, '0, '0, 16'hFFFF));
		send_beat(make_beat(OP_READ, '0, 9'd0, '0, '0, '0, '0));

		// full range, a middle window, single frames at both ends, inverted
		// ranges, a few random pairs, and back to the reset setting
		seq_plan = '{12'o0077, 12'o0514, 12'o0000, 12'o7777, 12'o1205, 12'o7700,
			12'($urandom), 12'($urandom), 12'($urandom), 12'o0001};
		foreach (seq_plan[i]) begin
			set_seq(seq_plan[i][11:6], seq_plan[i][5:0]);
			run_phase(PHASE_BEATS);
		end

		drain();
		$display("tb_top: %0d input beats sent, %0d result beats checked",
			tracker.noted, tracker.checked);
		$display("tb_top: %0d blended reads, %0d frame advances, %0d sequence settings",
			tracker.reads, tracker.advances, settings);
		if (tracker.errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
